// ===== rtl/qslerp_pkg.sv =====
// qslerp_pkg: shared constants, tables, cell data types and pipeline stage map
// for the quaternion slerp pipeline. No dependencies.
package qslerp_pkg;

  // number formats
  localparam int FRAC_BITS        = 14;
  localparam int ANGLE_ITERATIONS = 16;
  localparam int WB               = 30;            // internal fraction bits

  // internal widths
  localparam int CW     = WB + 4;                  // cordic x / y
  localparam int ZW     = WB + 5;                  // cordic angle accumulator
  localparam int AW     = WB + 2;                  // unsigned angle, up to pi
  localparam int TW     = WB + 1;                  // blend in internal format
  localparam int DW     = WB + 2;                  // clamped dot product, signed
  localparam int SQ_QW  = WB + 1;                  // square root result
  localparam int SQ_RW  = WB + 3;                  // square root remainder
  localparam int SQ_DW  = 2 * WB + 2;              // square root radicand
  localparam int SQRT_N = SQ_DW / 2;               // one root bit per cell
  localparam int QB     = WB + 17;                 // quotient bits of a coefficient
  localparam int DIV_RW = SQ_QW + 1;               // divider remainder
  localparam int MW     = WB + 3;                  // magnitude of a sine
  localparam int KW     = QB + 1;                  // signed coefficient

  // saturation bounds of a result component
  localparam int SAT_HI = ((1 << FRAC_BITS) > 32767) ? 32767 : (1 << FRAC_BITS);
  localparam int SAT_LO = ((1 << FRAC_BITS) > 32768) ? -32768 : -(1 << FRAC_BITS);

  // angle constants in the internal format
  localparam logic [AW-1:0] Q_HALF_PI  = AW'(64'd1686629713);
  localparam logic [AW-1:0] Q_PI       = AW'(64'd3373259426);
  localparam logic [AW-1:0] Q_INV_GAIN = AW'(64'd652032874);

  // atan(2^-i) in the internal format, truncated
  localparam logic [30:0] ATAN_TAB [32] = '{
    31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
    31'd33543515, 31'd16775850, 31'd8388437, 31'd4194282, 31'd2097149,
    31'd1048575, 31'd524287, 31'd262143, 31'd131071, 31'd65535, 31'd32767,
    31'd16383, 31'd8191, 31'd4095, 31'd2047, 31'd1023, 31'd511, 31'd255,
    31'd127, 31'd63, 31'd31, 31'd15, 31'd7, 31'd3, 31'd1, 31'd0, 31'd0
  };

  typedef enum logic {CORDIC_VEC, CORDIC_ROT} cordic_mode_t;

  // data handed from cell to cell
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [SQ_RW-1:0] rem;
    logic [SQ_QW-1:0] root;
    logic [SQ_DW-1:0] rad;
  } sqrt_t;

  typedef struct packed {
    logic [DIV_RW-1:0] rem;
    logic [QB-1:0]     nq;
    logic [SQ_QW-1:0]  dvs;
  } div_t;

  // per-request sideband carried along the whole pipeline
  typedef struct packed {
    logic [3:0][15:0]     s;
    logic [3:0][15:0]     e;
    logic [TW-1:0]        tq;
    logic signed [DW-1:0] d;
    logic [SQ_QW-1:0]     sn;
  } side_t;

  // stage map: index of the register stage holding each result
  localparam int ST_DOT  = 0;
  localparam int ST_D    = ST_DOT + 1;
  localparam int ST_SQR  = ST_D + 1;
  localparam int ST_SQ0  = ST_SQR + 1;
  localparam int ST_VEC0 = ST_SQ0 + SQRT_N;
  localparam int ST_ANG  = ST_VEC0 + ANGLE_ITERATIONS;
  localparam int ST_RND  = ST_ANG + 1;
  localparam int ST_SIN0 = ST_RND + 1;
  localparam int ST_ABS  = ST_SIN0 + ANGLE_ITERATIONS;
  localparam int ST_DIV0 = ST_ABS + 1;
  localparam int ST_SGN  = ST_DIV0 + QB;
  localparam int ST_MUL  = ST_SGN + 1;
  localparam int ST_OUT  = ST_MUL + 1;
  localparam int NST     = ST_OUT + 1;

endpackage

// ===== rtl/quaternion_slerp_top.sv =====
// quaternion_slerp_top: fully pipelined fixed-point quaternion slerp.
// Depends on qslerp_pkg, qslerp_sqrt_cell, qslerp_cordic_cell, qslerp_div_cell.
//
// Usage:
//   s_* carries one request per beat: start and end quaternions (Q1.14) and
//   the blend fraction (UQ1.14). m_* returns the interpolated quaternion with
//   the degenerate flag on m_tuser (start passed through when sin(theta) = 0).
//   The pipeline is a row of cells: dot product, 31 square root cells,
//   16 vectoring cordic cells, two rows of 16 sine cordic cells, two rows of
//   47 divider cells, then coefficient multiply and output rounding.
//   A new request can be taken every cycle while no result is held at the
//   output, so throughput is one request per clock.
//   All stages advance together: when the output register holds a result
//   that m_tready does not take, the whole pipeline holds and s_tready is
//   low; otherwise s_tready is high, even while the pipeline is full.
//   Reset clears all valid bits; data registers are not reset. There is no
//   start-up pass, requests are taken in the first cycle after reset.
module quaternion_slerp_top import qslerp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // start_x, start_y, start_z, start_w, end_x, end_y, end_z, end_w, blend, pad
  input  logic [143:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_x, out_y, out_z, out_w
  output logic [63:0]  m_tdata,
  // degenerate
  output logic         m_tuser
);

  localparam int DSH_L = (WB > 2 * FRAC_BITS) ? WB - 2 * FRAC_BITS : 0;
  localparam int DSH_R = (2 * FRAC_BITS > WB) ? 2 * FRAC_BITS - WB : 0;
  localparam longint DRND = (DSH_R > 0) ? (64'sd1 <<< (DSH_R - 1)) : 64'sd0;
  localparam longint QONE = 64'sd1 <<< WB;

  logic           adv;
  logic [NST-1:0] vld;
  side_t          side [NST];
  side_t          side_in [NST];

  // stage registers outside the cell rows
  logic signed [31:0]     prod [4];
  logic [2*WB:0]          sq;
  logic [2*AW-2:0]        pa, pb;
  logic [AW-1:0]          za, zb;
  logic [MW-1:0]          absa, absb;
  logic                   nega, negb;
  logic signed [KW-1:0]   ka, kb;
  logic signed [63:0]     pka [4];
  logic signed [63:0]     pkb [4];
  logic [3:0][15:0]       ores;
  logic                   odeg;

  // cell rows
  sqrt_t   sq_c  [SQRT_N+1];
  cordic_t vec_c [ANGLE_ITERATIONS+1];
  cordic_t sin_a [ANGLE_ITERATIONS+1];
  cordic_t sin_b [ANGLE_ITERATIONS+1];
  div_t    div_a [QB+1];
  div_t    div_b [QB+1];

  // combinational helpers
  logic [14:0]          t_in;
  logic [TW-1:0]        tq_in;
  logic signed [63:0]   dw;
  logic signed [DW-1:0] d_new;
  logic [WB:0]          mag;
  logic signed [DW-1:0] dv;
  logic [SQ_QW-1:0]     sn_v;
  logic signed [ZW-1:0] zc;
  logic [AW-1:0]        theta;
  logic [AW:0]          ra, rb;
  logic [TW-1:0]        tq_a;

  function automatic logic [15:0] sat16(input logic signed [63:0] v);
    if (v > SAT_HI) return 16'(SAT_HI);
    if (v < SAT_LO) return 16'(SAT_LO);
    return v[15:0];
  endfunction

  // global advance: everything moves unless a held result blocks the output
  assign adv      = !vld[ST_OUT] || m_tready;
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], s_tvalid};
    end
  end

  // blend clamp and dot product conversion
  always_comb begin
    t_in  = s_tdata[128 +: 15];
    if (t_in > 15'(1 << FRAC_BITS)) t_in = 15'(1 << FRAC_BITS);
    tq_in = TW'(t_in) << (WB - FRAC_BITS);
    dw = 64'(prod[0]) + 64'(prod[1]) + 64'(prod[2]) + 64'(prod[3]);
    dw = ((dw <<< DSH_L) + DRND) >>> DSH_R;
    if (dw > QONE) dw = QONE;
    if (dw < -QONE) dw = -QONE;
    d_new = DW'(dw);
  end

  // sideband shift line, with fields filled in where they are produced
  always_comb begin
    for (int k = 0; k < NST; k++) begin
      if (k == 0) begin
        side_in[k].s  = s_tdata[63:0];
        side_in[k].e  = s_tdata[127:64];
        side_in[k].tq = tq_in;
        side_in[k].d  = '0;
        side_in[k].sn = '0;
      end else begin
        side_in[k] = side[k-1];
        if (k == ST_D) side_in[k].d = d_new;
        if (k == ST_VEC0) side_in[k].sn = sq_c[SQRT_N].root;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NST; k++) side[k] <= side_in[k];
    end
  end

  // dot product terms and square of |d|
  always_comb begin
    dv  = side[ST_D].d;
    mag = (dv < 0) ? (WB+1)'(-dv) : (WB+1)'(dv);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        prod[i] <= $signed(s_tdata[16*i +: 16]) * $signed(s_tdata[64+16*i +: 16]);
      end
      sq <= (2*WB+1)'(mag * mag);
    end
  end

  // square root row: sin(theta) = sqrt(1 - d^2)
  assign sq_c[0].rem  = '0;
  assign sq_c[0].root = '0;
  assign sq_c[0].rad  = SQ_DW'((64'd1 << (2 * WB)) - 64'(sq));

  for (genvar i = 0; i < SQRT_N; i++) begin : g_sqrt
    qslerp_sqrt_cell u_cell (
      .clk (clk), .en (adv), .din (sq_c[i]), .dout (sq_c[i+1])
    );
  end

  // vectoring row: theta = atan2(sin, cos), left half-plane pre-turned by pi/2
  always_comb begin
    sn_v = sq_c[SQRT_N].root;
    if (side[ST_VEC0-1].d < 0) begin
      vec_c[0].x = CW'(sn_v);
      vec_c[0].y = -CW'(side[ST_VEC0-1].d);
      vec_c[0].z = ZW'(Q_HALF_PI);
    end else begin
      vec_c[0].x = CW'(side[ST_VEC0-1].d);
      vec_c[0].y = CW'(sn_v);
      vec_c[0].z = '0;
    end
  end

  for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_vec
    qslerp_cordic_cell u_cell (
      .clk (clk), .en (adv), .mode (CORDIC_VEC), .shift (5'(i)),
      .atan (ATAN_TAB[i]), .din (vec_c[i]), .dout (vec_c[i+1])
    );
  end

  // clamp theta and split it by the blend fraction
  always_comb begin
    zc = vec_c[ANGLE_ITERATIONS].z;
    if (zc < 0) theta = '0;
    else if (zc > $signed(ZW'(Q_PI))) theta = Q_PI;
    else theta = AW'(zc);
    tq_a = side[ST_ANG-1].tq;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa <= (2*AW-1)'(TW'((64'd1 << WB) - 64'(tq_a)) * theta);
      pb <= (2*AW-1)'(tq_a * theta);
    end
  end

  // round partial angles and fold them into the first quadrant
  always_comb begin
    ra = (AW+1)'((64'(pa) + (64'd1 << (WB - 1))) >> WB);
    rb = (AW+1)'((64'(pb) + (64'd1 << (WB - 1))) >> WB);
    if (ra > (AW+1)'(Q_HALF_PI)) ra = (AW+1)'(Q_PI) - ra;
    if (rb > (AW+1)'(Q_HALF_PI)) rb = (AW+1)'(Q_PI) - rb;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      za <= AW'(ra);
      zb <= AW'(rb);
    end
  end

  // sine rows
  assign sin_a[0].x = CW'(Q_INV_GAIN);
  assign sin_a[0].y = '0;
  assign sin_a[0].z = ZW'(za);
  assign sin_b[0].x = CW'(Q_INV_GAIN);
  assign sin_b[0].y = '0;
  assign sin_b[0].z = ZW'(zb);

  for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_sin
    qslerp_cordic_cell u_cell_a (
      .clk (clk), .en (adv), .mode (CORDIC_ROT), .shift (5'(i)),
      .atan (ATAN_TAB[i]), .din (sin_a[i]), .dout (sin_a[i+1])
    );
    qslerp_cordic_cell u_cell_b (
      .clk (clk), .en (adv), .mode (CORDIC_ROT), .shift (5'(i)),
      .atan (ATAN_TAB[i]), .din (sin_b[i]), .dout (sin_b[i+1])
    );
  end

  // sign and magnitude of the two sines
  always_ff @(posedge clk) begin
    if (adv) begin
      nega <= sin_a[ANGLE_ITERATIONS].y < 0;
      negb <= sin_b[ANGLE_ITERATIONS].y < 0;
      absa <= MW'((sin_a[ANGLE_ITERATIONS].y < 0) ? -sin_a[ANGLE_ITERATIONS].y
                                                  : sin_a[ANGLE_ITERATIONS].y);
      absb <= MW'((sin_b[ANGLE_ITERATIONS].y < 0) ? -sin_b[ANGLE_ITERATIONS].y
                                                  : sin_b[ANGLE_ITERATIONS].y);
    end
  end

  // divider rows: |sin| * 2^WB / sin(theta); top dividend bits preload the remainder
  assign div_a[0].rem = DIV_RW'(absa >> (QB - WB));
  assign div_a[0].nq  = {absa[QB-WB-1:0], {WB{1'b0}}};
  assign div_a[0].dvs = side[ST_ABS].sn;
  assign div_b[0].rem = DIV_RW'(absb >> (QB - WB));
  assign div_b[0].nq  = {absb[QB-WB-1:0], {WB{1'b0}}};
  assign div_b[0].dvs = side[ST_ABS].sn;

  for (genvar i = 0; i < QB; i++) begin : g_div
    qslerp_div_cell u_cell_a (
      .clk (clk), .en (adv), .din (div_a[i]), .dout (div_a[i+1])
    );
    qslerp_div_cell u_cell_b (
      .clk (clk), .en (adv), .din (div_b[i]), .dout (div_b[i+1])
    );
  end

  // sign delay line for the divider rows
  logic [QB-1:0] nega_d, negb_d;

  always_ff @(posedge clk) begin
    if (adv) begin
      nega_d <= {nega_d[QB-2:0], nega};
      negb_d <= {negb_d[QB-2:0], negb};
    end
  end

  // signed coefficients, truncated toward zero
  always_ff @(posedge clk) begin
    if (adv) begin
      ka <= nega_d[QB-1] ? -$signed({1'b0, div_a[QB].nq}) : $signed({1'b0, div_a[QB].nq});
      kb <= negb_d[QB-1] ? -$signed({1'b0, div_b[QB].nq}) : $signed({1'b0, div_b[QB].nq});
    end
  end

  // coefficient products
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        pka[i] <= ka * $signed(side[ST_SGN].s[i]);
        pkb[i] <= kb * $signed(side[ST_SGN].e[i]);
      end
    end
  end

  // sum, round, saturate, or pass start through when degenerate
  always_ff @(posedge clk) begin
    if (adv) begin
      odeg <= (side[ST_MUL].sn == '0);
      for (int i = 0; i < 4; i++) begin
        if (side[ST_MUL].sn == '0) begin
          ores[i] <= sat16(64'($signed(side[ST_MUL].s[i])));
        end else begin
          ores[i] <= sat16(64'((65'(pka[i]) + 65'(pkb[i]) + (65'sd1 <<< (WB - 1)))
                               >>> WB));
        end
      end
    end
  end

  assign m_tvalid = vld[ST_OUT];
  assign m_tdata  = ores;
  assign m_tuser  = odeg;

  // a held result must hold the input side too
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("request taken while output stalled");

  // an accepted request enters the first stage
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> vld[0])
    else $error("accepted request lost at pipeline entry");

  // results stay inside the component range
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[15:0]) <= SAT_HI && $signed(m_tdata[15:0]) >= SAT_LO &&
                  $signed(m_tdata[31:16]) <= SAT_HI && $signed(m_tdata[31:16]) >= SAT_LO &&
                  $signed(m_tdata[47:32]) <= SAT_HI && $signed(m_tdata[47:32]) >= SAT_LO &&
                  $signed(m_tdata[63:48]) <= SAT_HI && $signed(m_tdata[63:48]) >= SAT_LO))
    else $error("result component out of range");

endmodule

// ===== rtl/qslerp_sqrt_cell.sv =====
// qslerp_sqrt_cell: one digit cell of the square root chain, one root bit per cell.
// Depends on qslerp_pkg.
module qslerp_sqrt_cell import qslerp_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  sqrt_t din,
  output sqrt_t dout
);

  logic [SQ_RW+1:0] t;
  logic [SQ_RW+1:0] trial;
  logic             ge;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    t     = {din.rem, din.rad[SQ_DW-1 -: 2]};
    trial = {2'b00, din.root, 2'b01};
    ge    = (t >= trial);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.rem  <= ge ? SQ_RW'(t - trial) : SQ_RW'(t);
      dout.root <= {din.root[SQ_QW-2:0], ge};
      dout.rad  <= {din.rad[SQ_DW-3:0], 2'b00};
    end
  end

endmodule

// ===== rtl/qslerp_cordic_cell.sv =====
// qslerp_cordic_cell: one micro-rotation of a cordic chain, vectoring or rotation.
// Depends on qslerp_pkg.
module qslerp_cordic_cell import qslerp_pkg::*; (
  input  logic         clk,
  input  logic         en,
  input  cordic_mode_t mode,
  input  logic [4:0]   shift,
  input  logic [30:0]  atan,
  input  cordic_t      din,
  output cordic_t      dout
);

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [ZW-1:0] ae;
  logic                 ccw;

  // floor shifts and turn direction
  always_comb begin
    dx  = din.y >>> shift;
    dy  = din.x >>> shift;
    ae  = $signed({{(ZW-31){1'b0}}, atan});
    ccw = (mode == CORDIC_ROT) ? (din.z >= 0) : !(din.y > 0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ccw) begin
        dout.x <= din.x - dx;
        dout.y <= din.y + dy;
        dout.z <= din.z - ae;
      end else begin
        dout.x <= din.x + dx;
        dout.y <= din.y - dy;
        dout.z <= din.z + ae;
      end
    end
  end

endmodule

// ===== rtl/qslerp_div_cell.sv =====
// qslerp_div_cell: one quotient bit of the restoring divider chain.
// Depends on qslerp_pkg.
module qslerp_div_cell import qslerp_pkg::*; (
  input  logic clk,
  input  logic en,
  input  div_t din,
  output div_t dout
);

  logic [DIV_RW:0] t;
  logic            ge;

  // shift in the next dividend bit and trial-subtract the divisor
  always_comb begin
    t  = {din.rem, din.nq[QB-1]};
    ge = (t >= {2'b00, din.dvs});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.rem <= ge ? DIV_RW'(t - {2'b00, din.dvs}) : DIV_RW'(t);
      dout.nq  <= {din.nq[QB-2:0], ge};
      dout.dvs <= din.dvs;
    end
  end

endmodule
